### hw/rtl/cdds_pkg.sv
// ============================================================================
// cdds_pkg: shared types and constants for the calendar date stepper
// Field widths, sequencer states, reciprocal constants and calendar tables.
// ============================================================================
package cdds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 3;
    localparam int OPND_W  = 15;   // operand of the reciprocal unit
    localparam int RCP_W   = 16;   // reciprocal constant width
    localparam int PROD_W  = OPND_W + RCP_W;
    localparam int Q100_W  = 8;    // year / 100, at most 163
    localparam int R100_W  = 7;    // year % 100

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MOVE = 1'b1;

    // floor(x / 100) = (x * 5243) >> 19 and floor(x / 7) = (x * 37450) >> 18
    // hold for every x below 2**15
    localparam logic [RCP_W-1:0] RECIP_100 = 16'd5243;
    localparam int               SHIFT_100 = 19;
    localparam logic [RCP_W-1:0] RECIP_7   = 16'd37450;
    localparam int               SHIFT_7   = 18;

    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_MAX   = 5'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_DIV,
        ST_STEP,
        ST_SUM,
        ST_DIV7,
        ST_DONE
    } state_t;

    typedef enum logic {
        DIV_BY_100,
        DIV_BY_7
    } div_sel_t;

    typedef struct packed {
        logic     load;
        div_sel_t sel;
    } mul_ctrl_t;

    // days in a month; months outside 1..12 count 30 days
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                                      len = leap ? 5'd29 : 5'd28;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            default:                                   len = 5'd30;
        endcase
        return len;
    endfunction

    // floor(3 * (m + 1) / 5)
    function automatic logic [3:0] month_term(input logic [MONTH_W-1:0] m);
        logic [3:0] t;
        case (m)
            4'd0:    t = 4'd0;
            4'd1:    t = 4'd1;
            4'd2:    t = 4'd1;
            4'd3:    t = 4'd2;
            4'd4:    t = 4'd3;
            4'd5:    t = 4'd3;
            4'd6:    t = 4'd4;
            4'd7:    t = 4'd4;
            4'd8:    t = 4'd5;
            4'd9:    t = 4'd6;
            4'd10:   t = 4'd6;
            4'd11:   t = 4'd7;
            4'd12:   t = 4'd7;
            4'd13:   t = 4'd8;
            4'd14:   t = 4'd9;
            default: t = 4'd9;
        endcase
        return t;
    endfunction

endpackage

### hw/rtl/cdds_recip.sv
// ============================================================================
// cdds_recip: shared constant-divide unit
// Multiplies by a fixed reciprocal and registers the product; the quotient
// is a shift of the registered product. Serves both /100 and /7.
// ============================================================================
module cdds_recip (
    input  logic                        clk,
    input  cdds_pkg::mul_ctrl_t         ctrl,
    input  logic [cdds_pkg::OPND_W-1:0] operand,
    output logic [cdds_pkg::OPND_W-1:0] quot
);
    import cdds_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    div_sel_t          sel_reg;
    logic [RCP_W-1:0]  recip;
    logic [PROD_W-1:0] shifted;

    always_comb
    begin
        case (ctrl.sel)
            DIV_BY_7: recip = RECIP_7;
            default:  recip = RECIP_100;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            prod_reg <= {{RCP_W{1'b0}}, operand} * {{OPND_W{1'b0}}, recip};
            sel_reg  <= ctrl.sel;
        end
    end

    always_comb
    begin
        case (sel_reg)
            DIV_BY_7: shifted = prod_reg >> SHIFT_7;
            default:  shifted = prod_reg >> SHIFT_100;
        endcase
    end

    assign quot = shifted[OPND_W-1:0];

endmodule

### hw/rtl/calendar_date_day_stepper.sv
// ============================================================================
// calendar_date_day_stepper: Gregorian date counter with weekday
// Loads a date or walks it a signed number of days, one day per cycle.
// ============================================================================
// One request is handled at a time; req_stall is high from acceptance until
// the response is in the output register. A load (opcode 0) divides the
// year by 100, forms the weekday sum and divides it by 7; a move (opcode 1)
// first walks |day_count| days, stopping early when the walk saturates at
// 9999-12-31 or 0001-01-01. The walk loop (one day per cycle) is the long
// part; the tail is the weekday sum and one pass through the shared
// reciprocal multiplier, which also derives year/100 on a load.
// The response register frees the request side: it holds a result while
// rsp_stall is high, and the sequencer only waits if a second result is
// ready before the first is taken.
// ============================================================================
module calendar_date_day_stepper #(
    parameter int COUNT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // request channel
    input  logic                         req_valid,
    output logic                         req_stall,
    input  logic                         opcode,
    input  logic [cdds_pkg::YEAR_W-1:0]  load_year,
    input  logic [cdds_pkg::MONTH_W-1:0] load_month,
    input  logic [cdds_pkg::DAY_W-1:0]   load_day,
    input  logic signed [COUNT_BITS-1:0] day_count,
    // response channel
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [cdds_pkg::YEAR_W-1:0]  cur_year,
    output logic [cdds_pkg::MONTH_W-1:0] cur_month,
    output logic [cdds_pkg::DAY_W-1:0]   cur_day,
    output logic [cdds_pkg::WDAY_W-1:0]  weekday,
    output logic                         saturated
);
    import cdds_pkg::*;

    // sequencer
    state_t state_reg, state_next;

    // stored date plus year/100 and year%100 kept alongside for leap tests
    logic [YEAR_W-1:0]  year_reg,  year_next;
    logic [MONTH_W-1:0] month_reg, month_next;
    logic [DAY_W-1:0]   day_reg,   day_next;
    logic [Q100_W-1:0]  q100_reg,  q100_next;
    logic [R100_W-1:0]  r100_reg,  r100_next;

    // walk control
    logic [COUNT_BITS-1:0] steps_reg, steps_next;
    logic                  neg_reg,   neg_next;
    logic                  sat_reg,   sat_next;

    // weekday sum, before mod 7
    logic [OPND_W-1:0] sum_reg, sum_next;

    // response register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [YEAR_W-1:0]  cur_year_reg,  cur_year_next;
    logic [MONTH_W-1:0] cur_month_reg, cur_month_next;
    logic [DAY_W-1:0]   cur_day_reg,   cur_day_next;
    logic [WDAY_W-1:0]  weekday_reg,   weekday_next;
    logic               saturated_reg, saturated_next;

    // shared divide unit
    mul_ctrl_t         mul_ctrl;
    logic [OPND_W-1:0] mul_operand;
    logic [OPND_W-1:0] mul_quot;

    cdds_recip u_recip (
        .clk     (clk),
        .ctrl    (mul_ctrl),
        .operand (mul_operand),
        .quot    (mul_quot)
    );

    // ------------------------------------------------------------------------
    // combinational helpers
    // ------------------------------------------------------------------------
    logic [COUNT_BITS-1:0] count_raw;
    logic [COUNT_BITS-1:0] count_mag;
    logic                  leap;
    logic [DAY_W-1:0]      cur_len;
    logic [MONTH_W-1:0]    prev_month;
    logic                  at_max;
    logic                  at_min;
    logic                  rsp_free;

    assign count_raw = day_count;
    assign count_mag = count_raw[COUNT_BITS-1]
                     ? (~count_raw) + {{(COUNT_BITS-1){1'b0}}, 1'b1}
                     : count_raw;

    // leap: divisible by 4 and not by 100, or divisible by 400
    assign leap = ((year_reg[1:0] == 2'd0) && (r100_reg != '0))
               || ((r100_reg == '0) && (q100_reg[1:0] == 2'd0));

    assign cur_len    = month_len(month_reg, leap);
    assign prev_month = (month_reg <= 4'd1) ? MONTH_MAX : month_reg - 4'd1;

    assign at_max = (year_reg > YEAR_MAX)
                 || ((year_reg == YEAR_MAX)
                     && ((month_reg > MONTH_MAX)
                         || ((month_reg == MONTH_MAX) && (day_reg >= DAY_MAX))));
    assign at_min = (year_reg < 14'd1)
                 || ((year_reg == 14'd1)
                     && ((month_reg < 4'd1)
                         || ((month_reg == 4'd1) && (day_reg <= 5'd1))));

    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // weekday congruence on shifted copies: January and February count as
    // months 13 and 14 of the previous year; year offset by 400
    logic                 m_wrap;
    logic [MONTH_W-1:0]   m_adj;
    logic [OPND_W-1:0]    y_adj;
    logic [Q100_W:0]      q_adj;
    logic [OPND_W-1:0]    wk_sum;

    assign m_wrap = (month_reg == 4'd1) || (month_reg == 4'd2);
    assign m_adj  = m_wrap ? month_reg + 4'd12 : month_reg;
    assign y_adj  = {1'b0, year_reg} + 15'd400 - (m_wrap ? 15'd1 : 15'd0);
    assign q_adj  = {1'b0, q100_reg}
                  + ((m_wrap && (r100_reg == '0)) ? 9'd3 : 9'd4);
    assign wk_sum = OPND_W'(day_reg)
                  + OPND_W'({m_adj, 1'b0})
                  + OPND_W'(month_term(m_adj))
                  + y_adj
                  + (y_adj >> 2)
                  - OPND_W'(q_adj)
                  + OPND_W'(q_adj >> 2);

    // ------------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (opcode == OP_LOAD) ? ST_LOAD_DIV : ST_STEP;
                end
            end
            ST_LOAD_DIV:
            begin
                state_next = ST_SUM;
            end
            ST_STEP:
            begin
                if ((steps_reg == '0) || (!neg_reg && at_max) || (neg_reg && at_min))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_DIV7;
            end
            ST_DIV7:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // datapath and outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        q100_next      = q100_reg;
        r100_next      = r100_reg;
        steps_next     = steps_reg;
        neg_next       = neg_reg;
        sat_next       = sat_reg;
        sum_next       = sum_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cur_year_next  = cur_year_reg;
        cur_month_next = cur_month_reg;
        cur_day_next   = cur_day_reg;
        weekday_next   = weekday_reg;
        saturated_next = saturated_reg;
        mul_ctrl.load  = 1'b0;
        mul_ctrl.sel   = DIV_BY_100;
        mul_operand    = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    sat_next = 1'b0;
                    if (opcode == OP_LOAD)
                    begin
                        year_next     = load_year;
                        month_next    = load_month;
                        day_next      = load_day;
                        steps_next    = '0;
                        mul_ctrl.load = 1'b1;
                        mul_operand   = {1'b0, load_year};
                    end
                    else
                    begin
                        steps_next = count_mag;
                        neg_next   = count_raw[COUNT_BITS-1];
                    end
                end
            end
            ST_LOAD_DIV:
            begin
                // remainder = year - 100 * quotient
                q100_next = mul_quot[Q100_W-1:0];
                r100_next = R100_W'({1'b0, year_reg}
                                    - (OPND_W'(mul_quot[Q100_W-1:0]) * 15'd100));
            end
            ST_STEP:
            begin
                if (steps_reg != '0)
                begin
                    if (!neg_reg && at_max)
                    begin
                        year_next  = YEAR_MAX;
                        month_next = MONTH_MAX;
                        day_next   = DAY_MAX;
                        q100_next  = 8'd99;
                        r100_next  = 7'd99;
                        sat_next   = 1'b1;
                        steps_next = '0;
                    end
                    else if (neg_reg && at_min)
                    begin
                        year_next  = 14'd1;
                        month_next = 4'd1;
                        day_next   = 5'd1;
                        q100_next  = 8'd0;
                        r100_next  = 7'd1;
                        sat_next   = 1'b1;
                        steps_next = '0;
                    end
                    else
                    begin
                        steps_next = steps_reg - {{(COUNT_BITS-1){1'b0}}, 1'b1};
                        if (!neg_reg)
                        begin
                            if (day_reg >= cur_len)
                            begin
                                day_next = 5'd1;
                                if (month_reg >= MONTH_MAX)
                                begin
                                    month_next = 4'd1;
                                    year_next  = year_reg + 14'd1;
                                    if (r100_reg == 7'd99)
                                    begin
                                        r100_next = '0;
                                        q100_next = q100_reg + 8'd1;
                                    end
                                    else
                                    begin
                                        r100_next = r100_reg + 7'd1;
                                    end
                                end
                                else
                                begin
                                    month_next = month_reg + 4'd1;
                                end
                            end
                            else
                            begin
                                day_next = day_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            if (day_reg <= 5'd1)
                            begin
                                // February is only reached from March, same year
                                month_next = prev_month;
                                day_next   = month_len(prev_month, leap);
                                if (month_reg <= 4'd1)
                                begin
                                    year_next = year_reg - 14'd1;
                                    if (r100_reg == '0)
                                    begin
                                        r100_next = 7'd99;
                                        q100_next = q100_reg - 8'd1;
                                    end
                                    else
                                    begin
                                        r100_next = r100_reg - 7'd1;
                                    end
                                end
                            end
                            else
                            begin
                                day_next = day_reg - 5'd1;
                            end
                        end
                    end
                end
            end
            ST_SUM:
            begin
                sum_next = wk_sum;
            end
            ST_DIV7:
            begin
                mul_ctrl.load = 1'b1;
                mul_ctrl.sel  = DIV_BY_7;
                mul_operand   = sum_reg;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next = 1'b1;
                    cur_year_next  = year_reg;
                    cur_month_next = month_reg;
                    cur_day_next   = day_reg;
                    weekday_next   = WDAY_W'(sum_reg - (mul_quot * 15'd7));
                    saturated_next = sat_reg;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            year_reg      <= 14'd1;
            month_reg     <= 4'd1;
            day_reg       <= 5'd1;
            q100_reg      <= 8'd0;
            r100_reg      <= 7'd1;
            steps_reg     <= '0;
            neg_reg       <= 1'b0;
            sat_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            q100_reg      <= q100_next;
            r100_reg      <= r100_next;
            steps_reg     <= steps_next;
            neg_reg       <= neg_next;
            sat_reg       <= sat_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        cur_year_reg  <= cur_year_next;
        cur_month_reg <= cur_month_next;
        cur_day_reg   <= cur_day_next;
        weekday_reg   <= weekday_next;
        saturated_reg <= saturated_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign cur_year  = cur_year_reg;
    assign cur_month = cur_month_reg;
    assign cur_day   = cur_day_reg;
    assign weekday   = weekday_reg;
    assign saturated = saturated_reg;

endmodule
